FILE: hdl/trs_pkg.sv
// Shared types and constants for the translation embedding rank scorer.
// No dependencies.
package trs_pkg;

    localparam int ELEM_W  = 16;
    localparam int DIFF_W  = 18;
    localparam int MAG_W   = 17;
    localparam int TERM_W  = 34;
    localparam int ACC_W   = 48;
    localparam int RANK_W  = 17;
    localparam int CFG_IDX_W = 8;

    localparam logic [ACC_W-1:0]  ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [RANK_W-1:0] COUNT_MAX = 17'd131070;

    localparam logic [RANK_W-1:0] CUTOFF_RESET = 17'd10;
    localparam logic              MODE_RESET   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HITS_CUTOFF   = 8'd1;

    // op codes
    localparam logic OP_REFERENCE = 1'b0;
    localparam logic OP_CANDIDATE = 1'b1;

    // distance modes
    localparam logic MODE_L2 = 1'b0;
    localparam logic MODE_L1 = 1'b1;

    typedef struct packed {
        logic op;
        logic last_dim;
        logic known;
        logic last_candidate;
    } step_ctrl_t;

    typedef struct packed {
        logic [RANK_W-1:0] raw_rank;
        logic [RANK_W-1:0] filtered_rank;
        logic              raw_hit;
        logic              filtered_hit;
    } rank_res_t;

endpackage

FILE: hdl/translation_embedding_rank_scorer_core.sv
// Top level of the translation embedding rank scorer: input register,
// config registers, term and rank units, result register.
// Depends on trs_pkg, trs_term, trs_rank.
//
// Usage:
//   s_ channel: one embedding element (head, relation, tail) per item, with
//   op, last_dim, known and last_candidate flags. A query streams the
//   reference triple, then candidate triples.
//   m_ channel: one result per query (ranks, hit flags, done_res), issued
//   when the last candidate's last dimension is processed.
//   cfg channel: cfg_index/cfg_data write distance_mode (0) or hits_cutoff (1);
//   always ready; the user writes only while the block is idle (not enforced).
// Path: an item is registered in the input register on acceptance and
// processed from there; its result is registered in the result register.
// Throughput: one item per cycle while no result is held back by a low
// m_ready, set by the accumulate and compare in the rank unit.
// Reset: all counters, accumulator and reference distance clear;
// distance_mode resets to L1, hits_cutoff to 10.
// Stall: while m_valid is held by a low m_ready, items that produce no
// result keep flowing; an item that would produce a result waits in the
// input register, and s_ready drops behind it.
module translation_embedding_rank_scorer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [trs_pkg::ELEM_W-1:0]    s_head_element,
    input  logic signed [trs_pkg::ELEM_W-1:0]    s_relation_element,
    input  logic signed [trs_pkg::ELEM_W-1:0]    s_tail_element,
    input  logic                                 s_last_dim,
    input  logic                                 s_known,
    input  logic                                 s_last_candidate,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [trs_pkg::RANK_W-1:0]    m_raw_rank,
    output logic        [trs_pkg::RANK_W-1:0]    m_filtered_rank,
    output logic                                 m_raw_hit,
    output logic                                 m_filtered_hit,
    output logic                                 m_done_res,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [trs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [trs_pkg::RANK_W-1:0]    cfg_data
);

    logic                              mode_reg;
    logic [trs_pkg::RANK_W-1:0]        cutoff_reg;

    logic                              in_valid_reg, in_valid_next;
    trs_pkg::step_ctrl_t               in_ctrl_reg;
    logic signed [trs_pkg::ELEM_W-1:0] in_head_reg, in_rel_reg, in_tail_reg;

    logic                              m_valid_reg;
    trs_pkg::rank_res_t                m_res_reg;

    logic                              res_cause, out_free, stage_go, in_load;
    logic [trs_pkg::TERM_W-1:0]        term;
    trs_pkg::rank_res_t                res;
    logic                              res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= trs_pkg::MODE_RESET;
            cutoff_reg <= trs_pkg::CUTOFF_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == trs_pkg::REG_DISTANCE_MODE) begin
                mode_reg <= cfg_data[0];
            end else if (cfg_index == trs_pkg::REG_HITS_CUTOFF) begin
                cutoff_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        res_cause = in_ctrl_reg.last_dim && in_ctrl_reg.last_candidate
                  && (in_ctrl_reg.op == trs_pkg::OP_CANDIDATE);
        out_free  = !m_valid_reg || m_ready;
        stage_go  = in_valid_reg && (!res_cause || out_free);
        s_ready   = !in_valid_reg || stage_go;
        in_load   = s_valid && s_ready;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (stage_go) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_ctrl_reg.op             <= s_op;
            in_ctrl_reg.last_dim       <= s_last_dim;
            in_ctrl_reg.known          <= s_known;
            in_ctrl_reg.last_candidate <= s_last_candidate;
            in_head_reg <= s_head_element;
            in_rel_reg  <= s_relation_element;
            in_tail_reg <= s_tail_element;
        end
    end

    trs_term u_term (
        .distance_mode    (mode_reg),
        .head_element     (in_head_reg),
        .relation_element (in_rel_reg),
        .tail_element     (in_tail_reg),
        .term             (term)
    );

    trs_rank u_rank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (stage_go),
        .ctrl        (in_ctrl_reg),
        .term        (term),
        .hits_cutoff (cutoff_reg),
        .res         (res),
        .res_valid   (res_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_raw_rank      = m_res_reg.raw_rank;
    assign m_filtered_rank = m_res_reg.filtered_rank;
    assign m_raw_hit       = m_res_reg.raw_hit;
    assign m_filtered_hit  = m_res_reg.filtered_hit;
    assign m_done_res      = 1'b1;

endmodule

FILE: hdl/trs_term.sv
// Per-element distance term: |t-h-r| or (t-h-r)^2.
// Depends on trs_pkg.
module trs_term (
    input  logic                                 distance_mode,
    input  logic signed [trs_pkg::ELEM_W-1:0]    head_element,
    input  logic signed [trs_pkg::ELEM_W-1:0]    relation_element,
    input  logic signed [trs_pkg::ELEM_W-1:0]    tail_element,
    output logic        [trs_pkg::TERM_W-1:0]    term
);

    logic signed [trs_pkg::DIFF_W-1:0] diff;
    logic        [trs_pkg::DIFF_W-1:0] neg_diff;
    logic        [trs_pkg::MAG_W-1:0]  mag;
    logic        [trs_pkg::TERM_W-1:0] square;

    always_comb begin
        diff = trs_pkg::DIFF_W'(tail_element) - trs_pkg::DIFF_W'(head_element)
             - trs_pkg::DIFF_W'(relation_element);
        neg_diff = -diff;
        mag = diff[trs_pkg::DIFF_W-1] ? neg_diff[trs_pkg::MAG_W-1:0]
                                      : diff[trs_pkg::MAG_W-1:0];
        square = trs_pkg::TERM_W'(mag) * trs_pkg::TERM_W'(mag);
        if (distance_mode == trs_pkg::MODE_L1) begin
            term = trs_pkg::TERM_W'(mag);
        end else begin
            term = square;
        end
    end

endmodule

FILE: hdl/trs_rank.sv
// Distance accumulator, reference compare and saturating rank counters.
// Depends on trs_pkg.
module trs_rank (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  trs_pkg::step_ctrl_t           ctrl,
    input  logic [trs_pkg::TERM_W-1:0]    term,
    input  logic [trs_pkg::RANK_W-1:0]    hits_cutoff,
    output trs_pkg::rank_res_t            res,
    output logic                          res_valid
);

    logic [trs_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [trs_pkg::ACC_W-1:0]  ref_reg, ref_next;
    logic [trs_pkg::RANK_W-1:0] better_reg, better_next;
    logic [trs_pkg::RANK_W-1:0] filt_reg, filt_next;
    logic [trs_pkg::ACC_W:0]    sum;
    logic [trs_pkg::ACC_W-1:0]  sat_sum;
    logic [trs_pkg::RANK_W-1:0] better_upd, filt_upd;
    logic                       is_better;

    always_comb begin
        sum  = {1'b0, acc_reg} + (trs_pkg::ACC_W+1)'(term);
        sat_sum = (sum >= {1'b0, trs_pkg::ACC_MAX}) ? trs_pkg::ACC_MAX
                                                    : sum[trs_pkg::ACC_W-1:0];
        is_better = (sat_sum < ref_reg);
        better_upd = better_reg;
        filt_upd   = filt_reg;
        if (is_better) begin
            if (better_reg < trs_pkg::COUNT_MAX) begin
                better_upd = better_reg + 1'b1;
            end
            if (!ctrl.known && filt_reg < trs_pkg::COUNT_MAX) begin
                filt_upd = filt_reg + 1'b1;
            end
        end

        res.raw_rank      = better_upd + 1'b1;
        res.filtered_rank = filt_upd + 1'b1;
        res.raw_hit       = (res.raw_rank <= hits_cutoff);
        res.filtered_hit  = (res.filtered_rank <= hits_cutoff);
        res_valid = step_en && ctrl.last_dim && (ctrl.op == trs_pkg::OP_CANDIDATE)
                  && ctrl.last_candidate;

        acc_next    = acc_reg;
        ref_next    = ref_reg;
        better_next = better_reg;
        filt_next   = filt_reg;
        if (step_en) begin
            if (!ctrl.last_dim) begin
                acc_next = sat_sum;
            end else begin
                acc_next = '0;
                if (ctrl.op == trs_pkg::OP_REFERENCE) begin
                    ref_next    = sat_sum;
                    better_next = '0;
                    filt_next   = '0;
                end else if (ctrl.last_candidate) begin
                    better_next = '0;
                    filt_next   = '0;
                end else begin
                    better_next = better_upd;
                    filt_next   = filt_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            ref_reg    <= '0;
            better_reg <= '0;
            filt_reg   <= '0;
        end else begin
            acc_reg    <= acc_next;
            ref_reg    <= ref_next;
            better_reg <= better_next;
            filt_reg   <= filt_next;
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for translation_embedding_rank_scorer_core: directed and
// random queries against an in-bench rank predictor, with random stalls on both channels.
// Depends on trs_pkg and the scorer RTL.
module tb_top;

    localparam int RUN_LIMIT        = 1_000_000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RX_HOLD_CYCLES   = 400;
    localparam int PHASE_ELEMS      = 275;

    typedef struct {
        logic               op;
        logic signed [15:0] head;
        logic signed [15:0] rel;
        logic signed [15:0] tail;
        logic               last_dim;
        logic               known;
        logic               last_cand;
    } elem_t;

    typedef enum {VAL_FULL, VAL_NEAR_ZERO, VAL_EXTREME} val_style_t;
    typedef enum {FLAW_NONE, FLAW_NO_REFERENCE, FLAW_OPEN_END, FLAW_NOISE} query_flaw_t;

    class rank_tracker;
        logic                       mode;
        logic [trs_pkg::RANK_W-1:0] cutoff;
        logic [trs_pkg::ACC_W-1:0]  acc;
        logic [trs_pkg::ACC_W-1:0]  ref_dist;
        logic [trs_pkg::RANK_W-1:0] better;
        logic [trs_pkg::RANK_W-1:0] filt_better;
        trs_pkg::rank_res_t         pending_ranks[$];
        int                         errors;

        function new();
            mode        = trs_pkg::MODE_RESET;
            cutoff      = trs_pkg::CUTOFF_RESET;
            acc         = '0;
            ref_dist    = '0;
            better      = '0;
            filt_better = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [trs_pkg::CFG_IDX_W-1:0] idx,
                              logic [trs_pkg::RANK_W-1:0] data);
            if (idx == trs_pkg::REG_DISTANCE_MODE) begin
                mode = data[0];
            end else if (idx == trs_pkg::REG_HITS_CUTOFF) begin
                cutoff = data;
            end
        endfunction

        function logic [trs_pkg::RANK_W-1:0] count_up(logic [trs_pkg::RANK_W-1:0] c);
            return (c < trs_pkg::COUNT_MAX) ? c + 1'b1 : trs_pkg::COUNT_MAX;
        endfunction

        function void take_element(elem_t e);
            int                         diff;
            logic [trs_pkg::MAG_W-1:0]  mag;
            logic [63:0]                term;
            logic [63:0]                room;
            logic [trs_pkg::ACC_W-1:0]  closed;
            logic [trs_pkg::RANK_W:0]   raw;
            logic [trs_pkg::RANK_W:0]   filt;
            trs_pkg::rank_res_t         r;
            diff = int'(e.tail) - int'(e.head) - int'(e.rel);
            mag  = trs_pkg::MAG_W'((diff < 0) ? -diff : diff);
            term = (mode == trs_pkg::MODE_L1) ? 64'(mag) : 64'(mag) * 64'(mag);
            room = 64'(trs_pkg::ACC_MAX) - 64'(acc);
            if (term >= room) begin
                acc = trs_pkg::ACC_MAX;
            end else begin
                acc = acc + term[trs_pkg::ACC_W-1:0];
            end
            if (!e.last_dim) return;
            closed = acc;
            acc = '0;
            if (e.op == trs_pkg::OP_REFERENCE) begin
                ref_dist    = closed;
                better      = '0;
                filt_better = '0;
                return;
            end
            if (closed < ref_dist) begin
                better = count_up(better);
                if (!e.known) filt_better = count_up(filt_better);
            end
            if (!e.last_cand) return;
            raw  = {1'b0, better} + 1'b1;
            filt = {1'b0, filt_better} + 1'b1;
            r.raw_rank      = raw[trs_pkg::RANK_W-1:0];
            r.filtered_rank = filt[trs_pkg::RANK_W-1:0];
            r.raw_hit       = (raw <= {1'b0, cutoff});
            r.filtered_hit  = (filt <= {1'b0, cutoff});
            pending_ranks = {pending_ranks, r};
            better      = '0;
            filt_better = '0;
        endfunction

        task report(string what, int got, int want);
            $display("@%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_ranks(trs_pkg::rank_res_t got, logic done);
            trs_pkg::rank_res_t want;
            if (pending_ranks.size() == 0) begin
                report("result with no query open", 1, 0);
                return;
            end
            want = pending_ranks.pop_front();
            if (got.raw_rank !== want.raw_rank)
                report("raw_rank", int'(got.raw_rank), int'(want.raw_rank));
            if (got.filtered_rank !== want.filtered_rank)
                report("filtered_rank", int'(got.filtered_rank), int'(want.filtered_rank));
            if (got.raw_hit !== want.raw_hit)
                report("raw_hit", int'(got.raw_hit), int'(want.raw_hit));
            if (got.filtered_hit !== want.filtered_hit)
                report("filtered_hit", int'(got.filtered_hit), int'(want.filtered_hit));
            if (done !== 1'b1)
                report("done_res", int'(done), 1);
        endtask
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_op;
    logic signed [trs_pkg::ELEM_W-1:0]   s_head_element;
    logic signed [trs_pkg::ELEM_W-1:0]   s_relation_element;
    logic signed [trs_pkg::ELEM_W-1:0]   s_tail_element;
    logic                                s_last_dim;
    logic                                s_known;
    logic                                s_last_candidate;
    logic                                m_valid;
    logic                                m_ready;
    logic [trs_pkg::RANK_W-1:0]          m_raw_rank;
    logic [trs_pkg::RANK_W-1:0]          m_filtered_rank;
    logic                                m_raw_hit;
    logic                                m_filtered_hit;
    logic                                m_done_res;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [trs_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [trs_pkg::RANK_W-1:0]          cfg_data;

    rank_tracker tracker = new();
    int          cycles = 0;
    int          elems_sent = 0;
    bit          tx_eager = 1'b0;
    bit          rx_hold_armed = 1'b0;

    translation_embedding_rank_scorer_core i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_head_element     (s_head_element),
        .s_relation_element (s_relation_element),
        .s_tail_element     (s_tail_element),
        .s_last_dim         (s_last_dim),
        .s_known            (s_known),
        .s_last_candidate   (s_last_candidate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_raw_rank         (m_raw_rank),
        .m_filtered_rank    (m_filtered_rank),
        .m_raw_hit          (m_raw_hit),
        .m_filtered_hit     (m_filtered_hit),
        .m_done_res         (m_done_res),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random per-item stalls, one long hold-off when armed
    initial begin : rank_sink
        int                 wait_left;
        int                 hold_left;
        bit                 eager;
        trs_pkg::rank_res_t got;
        m_ready   = 1'b0;
        wait_left = 0;
        hold_left = 0;
        eager     = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.raw_rank      = m_raw_rank;
                got.filtered_rank = m_filtered_rank;
                got.raw_hit       = m_raw_hit;
                got.filtered_hit  = m_filtered_hit;
                tracker.check_ranks(got, m_done_res);
                if (rx_hold_armed) begin
                    rx_hold_armed = 1'b0;
                    hold_left = RX_HOLD_CYCLES;
                end
                if ($urandom_range(0, 15) == 0) eager = !eager;
                wait_left = eager ? 0 : $urandom_range(0, 9);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic elem_t mk(logic op, int h, int r, int t, logic ld, logic kn, logic lc);
        elem_t e;
        e.op        = op;
        e.head      = 16'(h);
        e.rel       = 16'(r);
        e.tail      = 16'(t);
        e.last_dim  = ld;
        e.known     = kn;
        e.last_cand = lc;
        return e;
    endfunction

    function automatic logic signed [15:0] pick(val_style_t style);
        case (style)
            VAL_FULL:      return 16'($urandom);
            VAL_NEAR_ZERO: return 16'(int'($urandom_range(0, 8)) - 4);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic send_elem(elem_t e);
        int gap;
        if ($urandom_range(0, 19) == 0) tx_eager = !tx_eager;
        gap = tx_eager ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_op               <= e.op;
        s_head_element     <= e.head;
        s_relation_element <= e.rel;
        s_tail_element     <= e.tail;
        s_last_dim         <= e.last_dim;
        s_known            <= e.known;
        s_last_candidate   <= e.last_cand;
        s_valid            <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.take_element(e);
        elems_sent++;
    endtask

    // wait for every open query to report, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending_ranks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [trs_pkg::CFG_IDX_W-1:0] idx,
                             logic [trs_pkg::RANK_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_triple(logic op, int dims, val_style_t style, logic kn, logic lc);
        elem_t e;
        for (int d = 0; d < dims; d++) begin
            e.head      = pick(style);
            e.rel       = pick(style);
            e.tail      = pick(style);
            e.last_dim  = (d == dims - 1);
            e.op        = e.last_dim ? op : 1'($urandom);
            e.known     = e.last_dim ? kn : 1'($urandom);
            e.last_cand = e.last_dim ? lc : 1'($urandom);
            send_elem(e);
        end
    endtask

    task automatic random_query(bit broken);
        int          dims;
        int          ncand;
        int          cdims;
        val_style_t  style;
        query_flaw_t flaw;
        elem_t       noise;
        dims  = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 3);
        ncand = $urandom_range(1, 10);
        style = val_style_t'($urandom_range(0, 2));
        flaw  = broken ? query_flaw_t'($urandom_range(1, 3)) : FLAW_NONE;
        if (flaw != FLAW_NO_REFERENCE)
            send_triple(trs_pkg::OP_REFERENCE, dims, style, 1'($urandom), 1'($urandom));
        for (int c = 0; c < ncand; c++) begin
            cdims = ($urandom_range(0, 4) == 0) ? $urandom_range(1, dims + 2) : dims;
            if (flaw == FLAW_NOISE && $urandom_range(0, 3) == 0) begin
                noise = mk(1'($urandom), $urandom, $urandom, $urandom,
                           1'($urandom), 1'($urandom), 1'($urandom));
                send_elem(noise);
            end
            send_triple(trs_pkg::OP_CANDIDATE, cdims, style, 1'($urandom),
                        (c == ncand - 1) && (flaw != FLAW_OPEN_END));
        end
    endtask

    task automatic random_phase(logic mode, logic [trs_pkg::RANK_W-1:0] cutoff,
                                bit arm_hold, bit pause_midway);
        int stop_at;
        settle();
        cfg_write(trs_pkg::REG_DISTANCE_MODE, trs_pkg::RANK_W'(mode));
        cfg_write(trs_pkg::REG_HITS_CUTOFF, cutoff);
        rx_hold_armed = arm_hold;
        stop_at = elems_sent + PHASE_ELEMS;
        while (elems_sent < stop_at) begin
            if (pause_midway && elems_sent >= stop_at - PHASE_ELEMS / 2) begin
                pause_midway = 1'b0;
                settle();
            end
            random_query($urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_op               = trs_pkg::OP_REFERENCE;
        s_head_element     = '0;
        s_relation_element = '0;
        s_tail_element     = '0;
        s_last_dim         = 1'b0;
        s_known            = 1'b0;
        s_last_candidate   = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = trs_pkg::REG_DISTANCE_MODE;
        cfg_data           = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: L1, cutoff 10
        // candidate before any reference never counts as better
        send_elem(mk(trs_pkg::OP_CANDIDATE, 5, 3, 2, 1'b1, 1'b0, 1'b1));
        // reference: op and flags off the last dim are ignored, last_candidate too
        send_elem(mk(trs_pkg::OP_CANDIDATE, -32768, -32768, 32767, 1'b0, 1'b1, 1'b1));
        send_elem(mk(trs_pkg::OP_REFERENCE, 32767, 32767, -32768, 1'b1, 1'b1, 1'b1));
        // tie with the reference
        send_elem(mk(trs_pkg::OP_REFERENCE, -32768, -32768, 32767, 1'b0, 1'b0, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, 32767, 32767, -32768, 1'b1, 1'b0, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, 1, 1, 1, 1'b1, 1'b1, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, 0, 0, 0, 1'b1, 1'b0, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, -32768, -32768, 32767, 1'b0, 1'b0, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, -32768, -32768, 32767, 1'b1, 1'b0, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, 7, -3, 4, 1'b1, 1'b0, 1'b1));
        // next query reuses the held reference
        send_elem(mk(trs_pkg::OP_CANDIDATE, 2, 2, 2, 1'b1, 1'b0, 1'b1));

        settle();
        cfg_write(trs_pkg::REG_DISTANCE_MODE, trs_pkg::RANK_W'(trs_pkg::MODE_L2));
        cfg_write(trs_pkg::REG_HITS_CUTOFF, '0);
        send_elem(mk(trs_pkg::OP_REFERENCE, 0, 0, 3, 1'b1, 1'b0, 1'b0));
        send_elem(mk(trs_pkg::OP_CANDIDATE, 0, 0, 2, 1'b1, 1'b0, 1'b1));
        send_elem(mk(trs_pkg::OP_CANDIDATE, 0, 0, -3, 1'b1, 1'b1, 1'b1));

        random_phase(trs_pkg::MODE_L1, 17'd1, 1'b1, 1'b0);
        random_phase(trs_pkg::MODE_L2, 17'd65536, 1'b0, 1'b1);
        random_phase(trs_pkg::MODE_L1, trs_pkg::RANK_W'($urandom_range(2, 12)), 1'b0, 1'b0);
        random_phase(trs_pkg::MODE_L2, trs_pkg::RANK_W'($urandom_range(0, 6)), 1'b0, 1'b0);

        settle();
        if (tracker.errors == 0 && tracker.pending_ranks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
